>>> rtl/core/scc_pkg.sv
// Package for the shunt sensor CAN client: codes, command words and the
// job record passed from the front end to the result sequencer.
// No dependencies.
`timescale 1ns / 1ps

package scc_pkg;

   localparam int NUM_CHANNELS = 8;
   localparam int CHAN_CNT_W   = 4;
   localparam int ID_W         = 11;
   localparam int WORD_W       = 32;
   localparam int MAX_CMDS     = 3;
   localparam int CMD_CNT_W    = 2;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [WORD_W-1:0] CMD_STOP      = 32'h0000_0034;
   localparam logic [WORD_W-1:0] CMD_START     = 32'h0000_0134;
   localparam logic [WORD_W-1:0] CMD_RESET     = 32'h0000_0030;
   localparam logic [WORD_W-1:0] CMD_CHG_IN    = 32'h0000_0243;
   localparam logic [WORD_W-1:0] CMD_CHG_OUT   = 32'h0000_0343;
   localparam logic [WORD_W-1:0] CMD_CHAN_BASE = 32'h6400_4020;
   localparam logic [WORD_W-1:0] CMD_CYCLIC    = 32'h0000_0200;

   localparam logic [ID_W-1:0] RESET_REPLY_ID   = 11'd1297;
   localparam logic [ID_W-1:0] RESET_CURRENT_ID = 11'd1313;
   localparam logic [ID_W-1:0] RESET_VOLTAGE_ID = 11'd1314;
   localparam logic [ID_W-1:0] RESET_POWER_ID   = 11'd1318;

   typedef enum logic [1:0] {
      MODE_FRAME      = 2'd0,
      MODE_REQ_CHARGE = 2'd1,
      MODE_RESET_CNT  = 2'd2,
      MODE_INIT       = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      PH_INIT     = 2'd0,
      PH_OPERATE  = 2'd1,
      PH_REQ_OUT  = 2'd2,
      PH_READ_OUT = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      REG_REPLY_ID   = 2'd0,
      REG_CURRENT_ID = 2'd1,
      REG_VOLTAGE_ID = 2'd2,
      REG_POWER_ID   = 2'd3
   } csr_index_type;

   typedef struct packed {
      phase_type                 phase;
      logic signed [WORD_W-1:0]  current_ma;
      logic signed [WORD_W-1:0]  voltage_mv;
      logic signed [WORD_W-1:0]  power_w;
      logic        [WORD_W-1:0]  charge_in;
      logic        [WORD_W-1:0]  charge_out;
   } status_type;

   typedef struct packed {
      logic [MAX_CMDS-1:0][WORD_W-1:0] cmd;
      logic [CMD_CNT_W-1:0]            n_cmd;
      status_type                      status;
   } job_type;

   function automatic logic [WORD_W-1:0] swap_bytes(input logic [WORD_W-1:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

>>> rtl/core/scc_if.sv
// Channel interfaces for the shunt sensor CAN client: request and response.
// Depends on scc_pkg.
`timescale 1ns / 1ps

interface scc_req_if;
   import scc_pkg::*;
   logic              valid;
   logic              ready;
   logic [1:0]        mode;
   logic [ID_W-1:0]   msg_id;
   logic [WORD_W-1:0] data_low;
   logic [WORD_W-1:0] data_high;

   modport source (output valid, mode, msg_id, data_low, data_high, input ready);
   modport sink   (input valid, mode, msg_id, data_low, data_high, output ready);
endinterface

interface scc_rsp_if;
   import scc_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     send_valid;
   logic        [WORD_W-1:0] send_word;
   logic                     last;
   logic        [1:0]        phase;
   logic signed [WORD_W-1:0] current_ma;
   logic signed [WORD_W-1:0] voltage_mv;
   logic signed [WORD_W-1:0] power_w;
   logic        [WORD_W-1:0] charge_in;
   logic        [WORD_W-1:0] charge_out;

   modport source (output valid, send_valid, send_word, last, phase, current_ma,
                   voltage_mv, power_w, charge_in, charge_out, input ready);
   modport sink   (input valid, send_valid, send_word, last, phase, current_ma,
                   voltage_mv, power_w, charge_in, charge_out, output ready);
endinterface

>>> rtl/core/scc_front.sv
// Front end: takes requests, holds the ID registers and the sensor state,
// and builds one job (command list plus status) per request.
// Depends on scc_pkg and scc_if.
`timescale 1ns / 1ps

module scc_front import scc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   scc_req_if.sink           req,
   input  logic              csr_write_en,
   input  logic [1:0]        csr_index,
   input  logic [ID_W-1:0]   csr_wdata,
   input  logic              queue_full,
   output logic              job_push,
   output job_type           job
);

   logic [ID_W-1:0]       reply_id_ff, current_id_ff, voltage_id_ff, power_id_ff;
   phase_type             phase_ff, phase_in;
   logic [CHAN_CNT_W-1:0] chan_ff, chan_in;
   logic [WORD_W-1:0]     current_ff, current_in, voltage_ff, voltage_in;
   logic [WORD_W-1:0]     power_ff, power_in, chg_in_ff, chg_in_in;
   logic [WORD_W-1:0]     chg_out_ff, chg_out_in;
   logic                  req_fire;

   assign req.ready = !queue_full;
   assign req_fire  = req.valid && req.ready;
   assign job_push  = req_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         reply_id_ff   <= RESET_REPLY_ID;
         current_id_ff <= RESET_CURRENT_ID;
         voltage_id_ff <= RESET_VOLTAGE_ID;
         power_id_ff   <= RESET_POWER_ID;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            REG_REPLY_ID:   reply_id_ff   <= csr_wdata;
            REG_CURRENT_ID: current_id_ff <= csr_wdata;
            REG_VOLTAGE_ID: voltage_id_ff <= csr_wdata;
            REG_POWER_ID:   power_id_ff   <= csr_wdata;
            default:        reply_id_ff   <= reply_id_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_INIT;
         chan_ff    <= '0;
         current_ff <= '0;
         voltage_ff <= '0;
         power_ff   <= '0;
         chg_in_ff  <= '0;
         chg_out_ff <= '0;
      end else if (req_fire) begin
         phase_ff   <= phase_in;
         chan_ff    <= chan_in;
         current_ff <= current_in;
         voltage_ff <= voltage_in;
         power_ff   <= power_in;
         chg_in_ff  <= chg_in_in;
         chg_out_ff <= chg_out_in;
      end
   end

   always_comb begin
      logic [WORD_W-1:0]    meas;
      logic [WORD_W-1:0]    chan_word;
      logic [CMD_CNT_W-1:0] n;

      phase_in   = phase_ff;
      chan_in    = chan_ff;
      current_in = current_ff;
      voltage_in = voltage_ff;
      power_in   = power_ff;
      chg_in_in  = chg_in_ff;
      chg_out_in = chg_out_ff;
      job.cmd    = '0;
      n          = '0;

      // measurement is frame bytes 2..5
      meas = {req.data_high[15:0], req.data_low[31:16]};
      chan_word = CMD_CHAN_BASE | {{(WORD_W-CHAN_CNT_W){1'b0}}, chan_ff};
      if (chan_ff == 4'd0 || chan_ff == 4'd1 || chan_ff == 4'd5) begin
         chan_word = chan_word | CMD_CYCLIC;
      end

      case (mode_type'(req.mode))
         MODE_FRAME: begin
            if (phase_ff == PH_INIT && chan_ff == '0) begin
               job.cmd[0] = CMD_STOP;
               n = 2'd1;
            end
            if (req.msg_id == reply_id_ff) begin
               case (phase_ff)
                  PH_INIT: begin
                     if (chan_ff < CHAN_CNT_W'(NUM_CHANNELS)) begin
                        job.cmd[n] = chan_word;
                        chan_in = chan_ff + 4'd1;
                     end else begin
                        job.cmd[n] = CMD_START;
                        phase_in = PH_OPERATE;
                     end
                     n = n + 2'd1;
                  end
                  PH_REQ_OUT: begin
                     chg_in_in  = swap_bytes(req.data_high);
                     job.cmd[n] = CMD_CHG_OUT;
                     n = n + 2'd1;
                     phase_in = PH_READ_OUT;
                  end
                  PH_READ_OUT: begin
                     chg_out_in = swap_bytes(req.data_high);
                     phase_in   = PH_OPERATE;
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end else if (req.msg_id == current_id_ff) begin
               current_in = meas;
            end else if (req.msg_id == voltage_id_ff) begin
               voltage_in = meas;
            end else if (req.msg_id == power_id_ff) begin
               power_in = meas;
            end
         end
         MODE_REQ_CHARGE: begin
            job.cmd[0] = CMD_CHG_IN;
            n = 2'd1;
            phase_in = PH_REQ_OUT;
         end
         MODE_RESET_CNT: begin
            job.cmd[0] = CMD_STOP;
            job.cmd[1] = CMD_RESET;
            job.cmd[2] = CMD_START;
            n = 2'd3;
         end
         default: begin
            phase_in = PH_INIT;
            chan_in  = '0;
         end
      endcase

      job.n_cmd             = n;
      job.status.phase      = phase_in;
      job.status.current_ma = current_in;
      job.status.voltage_mv = voltage_in;
      job.status.power_w    = power_in;
      job.status.charge_in  = chg_in_in;
      job.status.charge_out = chg_out_in;
   end

endmodule

>>> rtl/core/scc_queue.sv
// Short job queue between the front end and the result sequencer.
// Depends on scc_pkg.
`timescale 1ns / 1ps

module scc_queue import scc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output job_type pop_data,
   output logic    empty
);

   job_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff;

   assign full     = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

>>> rtl/core/scc_back.sv
// Result sequencer: walks the command list of the head job and drives one
// response per command (or one empty response) through an output register.
// Depends on scc_pkg and scc_if.
`timescale 1ns / 1ps

module scc_back import scc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    queue_empty,
   input  job_type job,
   output logic    job_pop,
   scc_rsp_if.source rsp
);

   logic                 valid_ff;
   logic [CMD_CNT_W-1:0] idx_ff;
   logic                 send_valid_ff, last_ff;
   logic [WORD_W-1:0]    send_word_ff;
   status_type           status_ff;
   logic                 load, last_now;
   logic [WORD_W-1:0]    word_sel;

   assign load     = !queue_empty && (!valid_ff || rsp.ready);
   assign last_now = (job.n_cmd == '0) || (idx_ff == job.n_cmd - 2'd1);
   assign job_pop  = load && last_now;

   always_comb begin
      case (idx_ff)
         2'd0:    word_sel = job.cmd[0];
         2'd1:    word_sel = job.cmd[1];
         default: word_sel = job.cmd[2];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            idx_ff   <= last_now ? '0 : idx_ff + 2'd1;
         end else if (rsp.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         send_valid_ff <= (job.n_cmd != '0);
         send_word_ff  <= (job.n_cmd != '0) ? word_sel : '0;
         last_ff       <= last_now;
         status_ff     <= job.status;
      end
   end

   assign rsp.valid      = valid_ff;
   assign rsp.send_valid = send_valid_ff;
   assign rsp.send_word  = send_word_ff;
   assign rsp.last       = last_ff;
   assign rsp.phase      = status_ff.phase;
   assign rsp.current_ma = status_ff.current_ma;
   assign rsp.voltage_mv = status_ff.voltage_mv;
   assign rsp.power_w    = status_ff.power_w;
   assign rsp.charge_in  = status_ff.charge_in;
   assign rsp.charge_out = status_ff.charge_out;

endmodule

>>> rtl/core/shunt_sensor_can_client.sv
// Shunt sensor CAN client, top level.
// Requests pass through the queue; each gives max(1, command count) responses
// (1..3). Throughput: one request per cycle unless the queue is full; the
// sequencer emits one response per cycle unless held back by rsp.ready.
// Synchronous active-high reset: init phase, channel 0, values zero, default IDs.
`timescale 1ns / 1ps

module shunt_sensor_can_client import scc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   scc_req_if.sink         req_chan,
   scc_rsp_if.source       rsp_chan,
   input  logic            csr_write_en,
   input  logic [1:0]      csr_index,
   input  logic [ID_W-1:0] csr_wdata
);

   job_type push_job, head_job;
   logic    job_push, job_pop, queue_full, queue_empty;

   scc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req          (req_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .queue_full   (queue_full),
      .job_push     (job_push),
      .job          (push_job)
   );

   scc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_job),
      .full      (queue_full),
      .pop       (job_pop),
      .pop_data  (head_job),
      .empty     (queue_empty)
   );

   scc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .job         (head_job),
      .job_pop     (job_pop),
      .rsp         (rsp_chan)
   );

endmodule
